@@ src/hts_pkg.sv @@
// Package with the shared types, codes and sizes of the handle timer table.
`timescale 1ns / 1ps

package hts_pkg;

    // Table size and slot index width.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Action codes carried on the input tuser.
    typedef enum logic [3:0] {
        ACT_TICK     = 4'd0,
        ACT_ADD_CD   = 4'd1,
        ACT_SET_DUR  = 4'd2,
        ACT_START_CD = 4'd3,
        ACT_CHECK    = 4'd4,
        ACT_DELETE   = 4'd5,
        ACT_ADD_SW   = 4'd6,
        ACT_START_SW = 4'd7,
        ACT_STOP     = 4'd8,
        ACT_READ     = 4'd9
    } t_action;

    // Result status codes carried on the output tuser.
    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_INVALID = 3'd1,
        STS_RUNNING = 3'd2,
        STS_EXPIRED = 3'd3,
        STS_FULL    = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_FREE,
        S_SCAN_ID,
        S_EXEC,
        S_OUT
    } t_state;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_EQ,
        ALU_INC,
        ALU_SUB,
        ALU_GE_SUM
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        flag;
    } t_alu_rsp;

    // One slot record as stored in the slot memory.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] length;
        logic [31:0] start_ms;
        logic        autofree;
    } t_slot_rec;

    // Write and read request to the slot memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_slot_rec         wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ src/hts_alu.sv @@
// Shared arithmetic unit: equality, increment, subtract and sum compare.
`timescale 1ns / 1ps

module hts_alu (
    input  hts_pkg::t_alu_req i_req,
    output hts_pkg::t_alu_rsp o_rsp
);
    import hts_pkg::*;

    logic [32:0] sum;

    // Limit is formed at 33 bits so it never wraps.
    assign sum = {1'b0, i_req.b} + {1'b0, i_req.c};

    always_comb begin
        o_rsp = '0;
        case (i_req.op)
            ALU_EQ: begin
                o_rsp.flag = (i_req.a == i_req.b);
            end
            ALU_INC: begin
                o_rsp.res = i_req.a + 32'd1;
            end
            ALU_SUB: begin
                o_rsp.res = i_req.a - i_req.b;
            end
            ALU_GE_SUM: begin
                o_rsp.flag = ({1'b0, i_req.a} >= sum);
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

@@ src/hts_slot_ram.sv @@
// Slot record memory with one write port and one registered read port.
`timescale 1ns / 1ps

module hts_slot_ram (
    input  logic              i_clk,
    input  hts_pkg::t_ram_req i_req,
    output hts_pkg::t_slot_rec o_rdata
);
    import hts_pkg::*;

    t_slot_rec r_mem [SLOTS];
    t_slot_rec r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/hts_ctrl.sv @@
// Sequencer that scans the slot table and applies each action.
`timescale 1ns / 1ps

module hts_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [3:0]             i_action,
    input  logic [31:0]            i_timer_id,
    input  logic [31:0]            i_duration_ms,
    input  logic                   i_delete_when_expired,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [31:0]            o_new_id,
    output logic [31:0]            o_elapsed_ms,
    output hts_pkg::t_alu_req      o_alu_req,
    input  hts_pkg::t_alu_rsp      i_alu_rsp,
    output hts_pkg::t_ram_req      o_ram_req,
    input  hts_pkg::t_slot_rec     i_ram_rdata
);
    import hts_pkg::*;

    t_state            r_state, n_state;
    logic [3:0]        r_act, n_act;
    logic [31:0]       r_id, n_id;
    logic [31:0]       r_dur, n_dur;
    logic              r_af, n_af;
    logic [31:0]       r_clock, n_clock;
    logic [31:0]       r_last_id, n_last_id;
    logic [SLOTS-1:0]  r_used, n_used;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_pidx, n_pidx;
    logic              r_pv, n_pv;
    logic [2:0]        r_status, n_status;
    logic [31:0]       r_new_id, n_new_id;
    logic [31:0]       r_elapsed, n_elapsed;

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clock   <= '0;
            r_last_id <= '0;
            r_used    <= '0;
            r_pv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clock   <= n_clock;
            r_last_id <= n_last_id;
            r_used    <= n_used;
            r_pv      <= n_pv;
        end
    end

    // Request fields, scan counters and result payload.
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_id      <= n_id;
        r_dur     <= n_dur;
        r_af      <= n_af;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_status  <= n_status;
        r_new_id  <= n_new_id;
        r_elapsed <= n_elapsed;
    end

    // Next state, memory and arithmetic unit control.
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_id      = r_id;
        n_dur     = r_dur;
        n_af      = r_af;
        n_clock   = r_clock;
        n_last_id = r_last_id;
        n_used    = r_used;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pv      = r_pv;
        n_status  = r_status;
        n_new_id  = r_new_id;
        n_elapsed = r_elapsed;

        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        o_alu_req.op = ALU_EQ;
        o_alu_req.a  = i_ram_rdata.id;
        o_alu_req.b  = r_id;
        o_alu_req.c  = '0;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_pidx;
        o_ram_req.wdata = i_ram_rdata;
        o_ram_req.re    = 1'b0;
        o_ram_req.raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act     = i_action;
                    n_id      = i_timer_id;
                    n_dur     = i_duration_ms;
                    n_af      = i_delete_when_expired;
                    n_status  = STS_OK;
                    n_new_id  = '0;
                    n_elapsed = '0;
                    n_idx     = '0;
                    n_pv      = 1'b0;
                    if (i_action inside {ACT_ADD_CD, ACT_ADD_SW}) begin
                        n_state = S_SCAN_FREE;
                    end else if (i_action inside {ACT_SET_DUR, ACT_START_CD, ACT_CHECK,
                                                  ACT_DELETE, ACT_START_SW, ACT_STOP,
                                                  ACT_READ}) begin
                        n_state = S_SCAN_ID;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            // Walk the used bits for the lowest free slot and claim it, or report full.
            S_SCAN_FREE: begin
                o_alu_req.op = ALU_INC;
                o_alu_req.a  = r_last_id;
                if (!r_used[r_idx]) begin
                    n_used[r_idx]            = 1'b1;
                    n_last_id                = i_alu_rsp.res;
                    n_new_id                 = i_alu_rsp.res;
                    o_ram_req.we             = 1'b1;
                    o_ram_req.waddr          = r_idx;
                    o_ram_req.wdata.id       = i_alu_rsp.res;
                    o_ram_req.wdata.length   = (r_act == ACT_ADD_CD) ? r_dur : 32'd0;
                    o_ram_req.wdata.start_ms = '0;
                    o_ram_req.wdata.autofree = r_af;
                    n_state                  = S_OUT;
                end else if (r_idx == LAST_SLOT) begin
                    n_status = STS_FULL;
                    n_state  = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Read one slot per cycle; compare the slot read in the previous cycle.
            S_SCAN_ID: begin
                o_ram_req.re = 1'b1;
                n_pv         = 1'b1;
                n_pidx       = r_idx;
                if (r_idx != LAST_SLOT) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pv) begin
                    if (r_used[r_pidx] && i_alu_rsp.flag) begin
                        // Hold the matching record in the read register.
                        o_ram_req.re = 1'b0;
                        n_pidx       = r_pidx;
                        n_state      = S_EXEC;
                    end else if (r_pidx == LAST_SLOT) begin
                        n_status = STS_INVALID;
                        n_state  = S_OUT;
                    end
                end
            end

            // Apply the action to the clock or to the found slot.
            S_EXEC: begin
                n_state = S_OUT;
                case (r_act)
                    ACT_TICK: begin
                        o_alu_req.op = ALU_INC;
                        o_alu_req.a  = r_clock;
                        n_clock      = i_alu_rsp.res;
                    end
                    ACT_SET_DUR: begin
                        o_ram_req.we           = 1'b1;
                        o_ram_req.wdata.length = r_dur;
                    end
                    ACT_START_CD: begin
                        o_ram_req.we             = 1'b1;
                        o_ram_req.wdata.start_ms = r_clock;
                    end
                    ACT_CHECK: begin
                        o_alu_req.op = ALU_GE_SUM;
                        o_alu_req.a  = r_clock;
                        o_alu_req.b  = i_ram_rdata.start_ms;
                        o_alu_req.c  = i_ram_rdata.length;
                        if (i_alu_rsp.flag) begin
                            n_status = STS_EXPIRED;
                            if (i_ram_rdata.autofree) begin
                                n_used[r_pidx] = 1'b0;
                            end
                        end else begin
                            n_status = STS_RUNNING;
                        end
                    end
                    ACT_DELETE: begin
                        n_used[r_pidx] = 1'b0;
                    end
                    ACT_START_SW: begin
                        o_ram_req.we             = 1'b1;
                        o_ram_req.wdata.start_ms = r_clock;
                        o_ram_req.wdata.length   = '0;
                    end
                    ACT_STOP: begin
                        o_alu_req.op           = ALU_SUB;
                        o_alu_req.a            = r_clock;
                        o_alu_req.b            = i_ram_rdata.start_ms;
                        o_ram_req.we           = 1'b1;
                        o_ram_req.wdata.length = i_alu_rsp.res;
                    end
                    ACT_READ: begin
                        o_alu_req.op = ALU_SUB;
                        o_alu_req.a  = r_clock;
                        o_alu_req.b  = i_ram_rdata.start_ms;
                        if (i_ram_rdata.length == 32'd0) begin
                            n_elapsed = i_alu_rsp.res;
                        end else begin
                            n_elapsed = i_ram_rdata.length;
                        end
                    end
                    default: begin
                        // Unused codes leave all state alone.
                    end
                endcase
            end

            // Present the result until the receiver takes it.
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status     = r_status;
    assign o_new_id     = r_new_id;
    assign o_elapsed_ms = r_elapsed;

endmodule

@@ src/handle_timer_stopwatch_table.sv @@
// Top level of the handle-addressed timer and stopwatch table.
//
// Requests arrive on the s_ stream: tuser carries the action code, tdata
// the handle, the countdown length and the auto-delete flag. Each request
// gives exactly one result on the m_ stream: tuser carries the status,
// tdata the new handle and the elapsed time.
//
// The block takes one request at a time and lowers s_tready until its
// result has been taken. A tick or an unused code passes from S_IDLE
// through S_EXEC to S_OUT. An add walks the used bits one slot a cycle
// in S_SCAN_FREE, then presents its result in S_OUT. A handle lookup
// reads the slot memory one record a cycle through its single read port
// and compares in the shared unit in S_SCAN_ID, then applies the action
// to a found slot in S_EXEC before S_OUT. After the result is taken the
// block returns to S_IDLE before the next request is accepted.
//
// A synchronous reset clears the millisecond clock, the handle counter and
// all used bits; no clearing pass runs. While the receiver holds m_tready
// low the result stays on m_tdata and m_tuser and no request is accepted.
`timescale 1ns / 1ps

module handle_timer_stopwatch_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] timer_id, [63:32] duration_ms, [64] delete_when_expired, rest zero
    input  logic [71:0] s_tdata,
    // [3:0] action
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] new_id, [63:32] elapsed_ms
    output logic [63:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);
    import hts_pkg::*;

    t_alu_req  alu_req;
    t_alu_rsp  alu_rsp;
    t_ram_req  ram_req;
    t_slot_rec ram_rdata;
    logic [31:0] new_id;
    logic [31:0] elapsed_ms;

    // Sequencer.
    hts_ctrl u_ctrl (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (s_tvalid),
        .o_in_ready            (s_tready),
        .i_action              (s_tuser),
        .i_timer_id            (s_tdata[31:0]),
        .i_duration_ms         (s_tdata[63:32]),
        .i_delete_when_expired (s_tdata[64]),
        .o_out_valid           (m_tvalid),
        .i_out_ready           (m_tready),
        .o_status              (m_tuser),
        .o_new_id              (new_id),
        .o_elapsed_ms          (elapsed_ms),
        .o_alu_req             (alu_req),
        .i_alu_rsp             (alu_rsp),
        .o_ram_req             (ram_req),
        .i_ram_rdata           (ram_rdata)
    );

    // Shared arithmetic unit.
    hts_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Slot record memory.
    hts_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign m_tdata = {elapsed_ms, new_id};

endmodule

@@ src/hts_checker.sv @@
// Port-level checks of the timer table, bound to the top level.
`timescale 1ns / 1ps

module hts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import hts_pkg::*;

    // No result is pending right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // The block never takes a request while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken while result pending");

    // An accepted request makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accept");

    // A stalled result holds.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == STS_OK || m_tuser == STS_INVALID ||
                      m_tuser == STS_RUNNING || m_tuser == STS_EXPIRED ||
                      m_tuser == STS_FULL))
        else $error("undefined status code");

endmodule

bind handle_timer_stopwatch_table hts_checker u_hts_checker (.*);

@@ verif/tb_handle_timer_stopwatch_table.sv @@
// Self-checking testbench for the handle timer and stopwatch table.
`timescale 1ns / 1ps

module testbench;
    import hts_pkg::*;

    // Run sizes and limits.
    localparam int          REAL_ITEMS   = 1450;
    localparam int          MAX_GAP      = 8;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LONG_HOLD    = 300;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          PRINT_CAP    = 40;
    localparam logic [3:0]  ACT_CODE_MAX = 4'hF;

    // One request as sent on the input stream, with the idle cycles before it.
    typedef struct {
        logic [3:0]  action;
        logic [31:0] timer_id;
        logic [31:0] duration;
        logic        autofree;
        int unsigned gap;
    } t_request;

    // One result as it should appear on the output stream.
    typedef struct {
        t_status     status;
        logic [31:0] new_id;
        logic [31:0] elapsed;
    } t_outcome;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [31:0] timer_id, [63:32] duration_ms, [64] delete_when_expired, rest zero
    logic [71:0] s_tdata  = '0;
    // [3:0] action
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [31:0] new_id, [63:32] elapsed_ms
    logic [63:0] m_tdata;
    // [2:0] status
    logic [2:0]  m_tuser;

    // Shadow copy of the timer table, in its reset state at the start.
    logic [31:0] tbl_clock    = '0;
    logic [31:0] tbl_last_id  = '0;
    logic        tbl_used     [SLOTS] = '{default: 1'b0};
    logic [31:0] tbl_id       [SLOTS];
    logic [31:0] tbl_length   [SLOTS];
    logic [31:0] tbl_begin    [SLOTS];
    logic        tbl_autofree [SLOTS];

    t_request    request_q[$];
    t_outcome    outcome_q[$];
    t_request    in_flight;
    int unsigned gap_count;
    int unsigned hold_left;
    int unsigned n_pushed;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned cycle_count;
    int unsigned long_count;
    logic        long_hold;
    logic        long_done;

    handle_timer_stopwatch_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and a single reset at the start.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Print one mismatch line while under the print cap, and count every one.
    task automatic log_mismatch(input string what);
        if (n_errors < PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        n_errors++;
    endtask

    // Apply one request to the shadow table and return the result it gives.
    function automatic t_outcome table_step(input t_request req);
        t_outcome    res;
        int          hit;
        int          spare_slot;
        int          i;
        logic [32:0] deadline;
        res.status  = STS_OK;
        res.new_id  = '0;
        res.elapsed = '0;
        hit         = -1;
        spare_slot  = -1;
        // Scan downward so both searches end on the lowest matching index.
        for (i = SLOTS - 1; i >= 0; i--) begin
            if (!tbl_used[i]) spare_slot = i;
            if (tbl_used[i] && tbl_id[i] == req.timer_id) hit = i;
        end
        if (req.action == ACT_TICK) begin
            tbl_clock = tbl_clock + 32'd1;
        end else if (req.action == ACT_ADD_CD || req.action == ACT_ADD_SW) begin
            if (spare_slot < 0) begin
                res.status = STS_FULL;
            end else begin
                tbl_last_id              = tbl_last_id + 32'd1;
                tbl_used[spare_slot]     = 1'b1;
                tbl_id[spare_slot]       = tbl_last_id;
                tbl_length[spare_slot]   = (req.action == ACT_ADD_CD) ? req.duration : '0;
                tbl_begin[spare_slot]    = '0;
                tbl_autofree[spare_slot] = req.autofree;
                res.new_id               = tbl_last_id;
            end
        end else if (req.action <= ACT_READ) begin
            if (hit < 0) begin
                res.status = STS_INVALID;
            end else begin
                case (req.action)
                    ACT_SET_DUR: tbl_length[hit] = req.duration;
                    ACT_START_CD: tbl_begin[hit] = tbl_clock;
                    ACT_CHECK: begin
                        // The deadline is compared at 33 bits, so it never wraps.
                        deadline = {1'b0, tbl_begin[hit]} + {1'b0, tbl_length[hit]};
                        if ({1'b0, tbl_clock} >= deadline) begin
                            res.status = STS_EXPIRED;
                            if (tbl_autofree[hit]) tbl_used[hit] = 1'b0;
                        end else begin
                            res.status = STS_RUNNING;
                        end
                    end
                    ACT_DELETE: tbl_used[hit] = 1'b0;
                    ACT_START_SW: begin
                        tbl_begin[hit]  = tbl_clock;
                        tbl_length[hit] = '0;
                    end
                    ACT_STOP: tbl_length[hit] = tbl_clock - tbl_begin[hit];
                    default: begin
                        // A running stopwatch reads live, a stopped one its stored time.
                        if (tbl_length[hit] == '0) res.elapsed = tbl_clock - tbl_begin[hit];
                        else                       res.elapsed = tbl_length[hit];
                    end
                endcase
            end
        end
        return res;
    endfunction

    // Queue one request; every fourth stretch of 120 requests goes without gaps.
    task automatic push_req(input logic [3:0] action, input logic [31:0] timer_id,
                            input logic [31:0] duration, input logic autofree);
        t_request req;
        req.action   = action;
        req.timer_id = timer_id;
        req.duration = duration;
        req.autofree = autofree;
        req.gap      = ((n_pushed / 120) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
        request_q    = {request_q, req};
        n_pushed++;
    endtask

    // Mostly a live handle, sometimes a recent stale one or random bits.
    function automatic logic [31:0] pick_handle();
        logic [31:0] live[$];
        int          i;
        int unsigned r;
        for (i = 0; i < SLOTS; i++) begin
            if (tbl_used[i]) live = {live, tbl_id[i]};
        end
        r = $urandom_range(0, 99);
        if (live.size() != 0 && r < 85) return live[$urandom_range(0, live.size() - 1)];
        if (r < 95) return tbl_last_id - $urandom_range(0, 3);
        return $urandom();
    endfunction

    // Short lengths so timers expire, with full-range and near-maximum values mixed in.
    function automatic logic [31:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 12);
        if (r < 85) return $urandom();
        return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endfunction

    // Stimulus: a directed opening, then random requests in phases that fill
    // the table, drain it, and mix everything.
    initial begin : stimulus
        int unsigned n_real;
        int unsigned phase;
        int unsigned add_w;
        int unsigned del_w;
        int unsigned r;
        logic [3:0]  act;
        n_pushed = 0;
        n_real   = 0;
        wait (i_rst_n);

        // Lookups on an empty table, an unused code and a tick.
        push_req(ACT_READ, 32'h0, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_req(ACT_CODE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_req(ACT_TICK, 32'h0, 32'h0, 1'b0);
        // A zero-length countdown expires at once and frees itself.
        push_req(ACT_ADD_CD, 32'h0, 32'h0, 1'b1);
        push_req(ACT_CHECK, 32'd1, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'd1, 32'h0, 1'b0);
        // A maximum length must not wrap the deadline.
        push_req(ACT_ADD_CD, 32'h0, 32'hFFFF_FFFF, 1'b0);
        push_req(ACT_START_CD, 32'd2, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'd2, 32'h0, 1'b0);
        push_req(ACT_SET_DUR, 32'd2, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'd2, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'd2, 32'h0, 1'b0);
        // Stopwatch read while running, then after a stop.
        push_req(ACT_ADD_SW, 32'h0, 32'hFFFF_FFFF, 1'b1);
        push_req(ACT_TICK, 32'h0, 32'h0, 1'b0);
        push_req(ACT_TICK, 32'h0, 32'h0, 1'b0);
        push_req(ACT_READ, 32'd3, 32'h0, 1'b0);
        push_req(ACT_START_SW, 32'd3, 32'h0, 1'b0);
        push_req(ACT_TICK, 32'h0, 32'h0, 1'b0);
        push_req(ACT_STOP, 32'd3, 32'h0, 1'b0);
        push_req(ACT_READ, 32'd3, 32'h0, 1'b0);
        push_req(ACT_CHECK, 32'd3, 32'h0, 1'b0);
        push_req(ACT_DELETE, 32'd2, 32'h0, 1'b0);
        push_req(ACT_DELETE, 32'd2, 32'h0, 1'b0);
        n_real = n_pushed - 1;

        // Random part, generated a couple of requests ahead of the driver.
        while (n_real < REAL_ITEMS) begin
            @(negedge i_clk);
            if (request_q.size() < 2) begin
                phase = (n_real / 150) % 3;
                add_w = (phase == 1) ? 45 : ((phase == 2) ? 4 : 16);
                del_w = (phase == 2) ? 20 : 5;
                r     = $urandom_range(0, 99);
                if (r < 3) begin
                    act = $urandom_range(ACT_READ + 1, ACT_CODE_MAX);
                    push_req(act, $urandom(), $urandom(), $urandom_range(0, 1));
                end else begin
                    if (r < 25) begin
                        act = ACT_TICK;
                    end else if (r < 25 + add_w) begin
                        act = $urandom_range(0, 1) ? ACT_ADD_CD : ACT_ADD_SW;
                    end else if (r < 25 + add_w + del_w) begin
                        act = ACT_DELETE;
                    end else begin
                        case ($urandom_range(0, 6))
                            0:       act = ACT_SET_DUR;
                            1:       act = ACT_START_CD;
                            2:       act = ACT_START_SW;
                            3:       act = ACT_STOP;
                            4:       act = ACT_READ;
                            default: act = ACT_CHECK;
                        endcase
                    end
                    push_req(act, pick_handle(), pick_duration(), $urandom_range(0, 1));
                    n_real++;
                end
            end
        end

        // Wait for every result, then allow for a late extra one.
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (outcome_q.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        end
        if (n_errors == 0) begin
            $display("** handle_timer_stopwatch_table: PASSED **");
        end else begin
            $display("** handle_timer_stopwatch_table: FAILED **");
        end
        $finish;
    end

    // Driver: offers queued requests after their idle gap and predicts each
    // accepted request.
    always @(posedge i_clk) begin : drive
        t_request nxt;
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            gap_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_q = {outcome_q, table_step(in_flight)};
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && gap_count >= request_q[0].gap) begin
                    nxt = request_q.pop_front();
                    in_flight <= nxt;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'b0, nxt.autofree, nxt.duration, nxt.timer_id};
                    s_tuser   <= nxt.action;
                    gap_count <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (request_q.size() != 0) gap_count <= gap_count + 1;
                end
            end
        end
    end

    // Monitor: random stalls per result, with quiet stretches, and a
    // field-by-field compare against the oldest prediction.
    always @(posedge i_clk) begin : watch
        t_outcome    want;
        int unsigned hold_draw;
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            n_results <= 0;
        end else if (m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                log_mismatch("result with no request outstanding");
            end else begin
                want = outcome_q.pop_front();
                if (m_tuser != want.status) begin
                    log_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
                end
                if (m_tdata[31:0] != want.new_id) begin
                    log_mismatch($sformatf("new_id got %0h want %0h",
                                           m_tdata[31:0], want.new_id));
                end
                if (m_tdata[63:32] != want.elapsed) begin
                    log_mismatch($sformatf("elapsed_ms got %0h want %0h",
                                           m_tdata[63:32], want.elapsed));
                end
            end
            n_results <= n_results + 1;
            hold_draw = ((n_results / 130) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            hold_left <= hold_draw;
            m_tready  <= (hold_draw == 0) && !long_hold;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !long_hold;
        end
    end

    // One long receiver hold-off partway through, while requests keep coming.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold  <= 1'b0;
            long_done  <= 1'b0;
            long_count <= 0;
        end else if (long_hold) begin
            if (long_count == LONG_HOLD) begin
                long_hold <= 1'b0;
                long_done <= 1'b1;
            end
            long_count <= long_count + 1;
        end else if (!long_done && n_results >= 500) begin
            long_hold <= 1'b1;
        end
    end

    // Timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** handle_timer_stopwatch_table: FAILED **");
            $finish;
        end
    end

endmodule
